// File: rtl/core/rits_pkg.sv
// Shared types and constants of the rounded integer-times-square-root pipeline.
package rits_pkg;

	localparam int unsigned OUT_WIDTH = 36;

	typedef struct packed {
		logic valid;
		logic neg;
	} rits_ctl_t;

endpackage

// File: rtl/core/rits_gain_stage.sv
// One pipeline stage that brings in the next multiplier bit and forms the new residual gain.
module rits_gain_stage #(
	parameter int unsigned MW  = 32,
	parameter int unsigned RW  = 8,
	parameter int unsigned XW  = 38,
	parameter int unsigned AW  = 5,
	parameter int unsigned WW  = 47,
	parameter int unsigned MKW = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rits_pkg::rits_ctl_t ctl_in,
	input  logic [WW-1:0]       g_in,
	input  logic [WW-1:0]       c_in,
	input  logic [XW-1:0]       x_in,
	input  logic [AW-1:0]       a_in,
	input  logic [MKW-1:0]      mk_in,
	input  logic [RW-1:0]       k_in,
	input  logic [MW-1:0]       mag_in,
	output rits_pkg::rits_ctl_t ctl_out,
	output logic [WW-1:0]       g_out,
	output logic [WW-1:0]       c_out,
	output logic [XW-1:0]       x_out,
	output logic [AW-1:0]       a_out,
	output logic [MKW-1:0]      mk_out,
	output logic [RW-1:0]       k_out,
	output logic [MW-1:0]       mag_out
);
	import rits_pkg::*;

	rits_ctl_t      ctl_s1;
	logic [WW-1:0]  g_s1;
	logic [XW-1:0]  x_s1;
	logic [MKW-1:0] mk_s1;
	logic [RW-1:0]  k_s1;
	logic [MW-1:0]  mag_s1;

	logic           bit_in;
	logic [WW-1:0]  term;
	logic [WW-1:0]  g_next;
	logic [XW-1:0]  x_next;
	logic [MKW-1:0] mk_next;

	// gain = 4*(g - c) + b*(4*m*k + k); m*k is carried along as mk
	always_comb begin
		bit_in  = mag_in[MW-1];
		term    = bit_in ? ((WW'(mk_in) << 2) + WW'(k_in)) : '0;
		g_next  = ((g_in - c_in) << 2) + term;
		x_next  = (x_in << 1) + XW'(a_in);
		mk_next = (mk_in << 1) + (bit_in ? MKW'(k_in) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1   <= g_next;
			x_s1   <= x_next;
			mk_s1  <= mk_next;
			k_s1   <= k_in;
			mag_s1 <= mag_in << 1;
		end
	end

	assign ctl_out = ctl_s1;
	assign g_out   = g_s1;
	assign c_out   = '0;
	assign x_out   = x_s1;
	assign a_out   = '0;
	assign mk_out  = mk_s1;
	assign k_out   = k_s1;
	assign mag_out = mag_s1;

endmodule

// File: rtl/core/rits_digit_stage.sv
// One pipeline stage that settles one bit of the added root digit.
module rits_digit_stage #(
	parameter int unsigned MW  = 32,
	parameter int unsigned RW  = 8,
	parameter int unsigned XW  = 38,
	parameter int unsigned AW  = 5,
	parameter int unsigned WW  = 47,
	parameter int unsigned MKW = 40,
	parameter int unsigned J   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rits_pkg::rits_ctl_t ctl_in,
	input  logic [WW-1:0]       g_in,
	input  logic [WW-1:0]       c_in,
	input  logic [XW-1:0]       x_in,
	input  logic [AW-1:0]       a_in,
	input  logic [MKW-1:0]      mk_in,
	input  logic [RW-1:0]       k_in,
	input  logic [MW-1:0]       mag_in,
	output rits_pkg::rits_ctl_t ctl_out,
	output logic [WW-1:0]       g_out,
	output logic [WW-1:0]       c_out,
	output logic [XW-1:0]       x_out,
	output logic [AW-1:0]       a_out,
	output logic [MKW-1:0]      mk_out,
	output logic [RW-1:0]       k_out,
	output logic [MW-1:0]       mag_out
);
	import rits_pkg::*;

	rits_ctl_t      ctl_s1;
	logic [WW-1:0]  g_s1;
	logic [WW-1:0]  c_s1;
	logic [XW-1:0]  x_s1;
	logic [AW-1:0]  a_s1;
	logic [MKW-1:0] mk_s1;
	logic [RW-1:0]  k_s1;
	logic [MW-1:0]  mag_s1;

	logic [WW-1:0]  step;
	logic [WW-1:0]  trial;
	logic           fits;

	// cost(a + d) = cost(a) + d*(4x + 2a + d), d = 2^J
	always_comb begin
		step  = ((WW'(x_in) << 2) + (WW'(a_in) << 1) + (WW'(1) << J)) << J;
		trial = c_in + step;
		fits  = (trial <= g_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1   <= g_in;
			c_s1   <= fits ? trial : c_in;
			x_s1   <= x_in;
			a_s1   <= fits ? (a_in | (AW'(1) << J)) : a_in;
			mk_s1  <= mk_in;
			k_s1   <= k_in;
			mag_s1 <= mag_in;
		end
	end

	assign ctl_out = ctl_s1;
	assign g_out   = g_s1;
	assign c_out   = c_s1;
	assign x_out   = x_s1;
	assign a_out   = a_s1;
	assign mk_out  = mk_s1;
	assign k_out   = k_s1;
	assign mag_out = mag_s1;

endmodule

// File: rtl/core/rits_final.sv
// Closing stages: last residual and root, then round the root up when the residual exceeds it.
module rits_final #(
	parameter int unsigned XW = 38,
	parameter int unsigned AW = 5,
	parameter int unsigned WW = 47
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rits_pkg::rits_ctl_t ctl_in,
	input  logic [WW-1:0]       g_in,
	input  logic [WW-1:0]       c_in,
	input  logic [XW-1:0]       x_in,
	input  logic [AW-1:0]       a_in,
	output rits_pkg::rits_ctl_t ctl_out,
	output logic [XW-1:0]       root
);
	import rits_pkg::*;

	rits_ctl_t     ctl_s1;
	rits_ctl_t     ctl_s2;
	logic [WW-1:0] r_s1;
	logic [XW-1:0] x_s1;
	logic [XW-1:0] root_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= g_in - c_in;
			x_s1    <= (x_in << 1) + XW'(a_in);
			root_s2 <= x_s1 + XW'(r_s1 > WW'(x_s1));
		end
	end

	assign ctl_out = ctl_s2;
	assign root    = root_s2;

endmodule

// File: rtl/core/rounded_int_times_sqrt_top.sv
// Top level: nearest integer to a signed multiplier times the square root of a small integer.
// AW = (RADICAND_WIDTH+1)/2 + 1 is the width of each digit added to the root.
// Throughput: one request per cycle while the output is not stalled; each multiplier bit takes
//   one gain stage and AW digit stages, one for each bit of the digit added to the root.
// Stall: all stages hold together while the output register keeps a result not yet taken.
// Reset: asynchronous, clears every stage's valid bit; payload registers are not reset.
module rounded_int_times_sqrt_top #(
	parameter int unsigned MULT_WIDTH     = 32,
	parameter int unsigned RADICAND_WIDTH = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [MULT_WIDTH-1:0]           multiplier,
	input  logic        [RADICAND_WIDTH-1:0]       radicand,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rits_pkg::OUT_WIDTH-1:0]  product_root
);
	import rits_pkg::*;

	localparam int unsigned MW   = MULT_WIDTH;
	localparam int unsigned RW   = RADICAND_WIDTH;
	// sqrt(k) < 2^HALF, so each added digit stays below 2^(HALF+1)
	localparam int unsigned HALF = (RW + 1) / 2;
	localparam int unsigned AW   = HALF + 1;
	localparam int unsigned XW   = MW + HALF + 1;
	localparam int unsigned WW   = XW + AW + 4;
	localparam int unsigned MKW  = MW + RW;
	localparam int unsigned PER  = AW + 1;
	localparam int unsigned NS   = MW * PER;

	logic                 out_valid_q;
	logic [OUT_WIDTH-1:0] result_q;

	// One enable for the whole pipe: advance whenever the output slot is free or drains.
	logic en;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Input stage: split off the sign and hold the magnitude.
	rits_ctl_t     ctl_s0;
	logic [MW-1:0] mag_s0;
	logic [RW-1:0] k_s0;
	logic [MW-1:0] mag_in;

	// The most negative value maps to 2^(MW-1), which fits the unsigned magnitude.
	assign mag_in = multiplier[MW-1] ? MW'($unsigned(~multiplier) + 1'b1)
	                                 : $unsigned(multiplier);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (en) begin
			ctl_s0.valid <= in_valid;
			ctl_s0.neg   <= multiplier[MW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s0 <= mag_in;
			k_s0   <= radicand;
		end
	end

	// Stage links; entry 0 is the input stage, entry NS the last digit stage.
	rits_ctl_t      ctl_w [0:NS];
	logic [WW-1:0]  g_w   [0:NS];
	logic [WW-1:0]  c_w   [0:NS];
	logic [XW-1:0]  x_w   [0:NS];
	logic [AW-1:0]  a_w   [0:NS];
	logic [MKW-1:0] mk_w  [0:NS];
	logic [RW-1:0]  k_w   [0:NS];
	logic [MW-1:0]  mag_w [0:NS];

	// Start with empty root, residual and multiplier prefix.
	assign ctl_w[0] = ctl_s0;
	assign g_w[0]   = '0;
	assign c_w[0]   = '0;
	assign x_w[0]   = '0;
	assign a_w[0]   = '0;
	assign mk_w[0]  = '0;
	assign k_w[0]   = k_s0;
	assign mag_w[0] = mag_s0;

	for (genvar i = 0; i < MW; i++) begin : g_bit
		localparam int unsigned BASE = i * PER;

		// Take in the next multiplier bit, most significant first.
		rits_gain_stage #(
			.MW(MW), .RW(RW), .XW(XW), .AW(AW), .WW(WW), .MKW(MKW)
		) u_gain (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_in(ctl_w[BASE]), .g_in(g_w[BASE]), .c_in(c_w[BASE]),
			.x_in(x_w[BASE]), .a_in(a_w[BASE]), .mk_in(mk_w[BASE]),
			.k_in(k_w[BASE]), .mag_in(mag_w[BASE]),
			.ctl_out(ctl_w[BASE+1]), .g_out(g_w[BASE+1]), .c_out(c_w[BASE+1]),
			.x_out(x_w[BASE+1]), .a_out(a_w[BASE+1]), .mk_out(mk_w[BASE+1]),
			.k_out(k_w[BASE+1]), .mag_out(mag_w[BASE+1])
		);

		// Find the largest digit that keeps the residual non-negative, top bit first.
		for (genvar q = 1; q <= AW; q++) begin : g_dig
			localparam int unsigned S = BASE + q;

			rits_digit_stage #(
				.MW(MW), .RW(RW), .XW(XW), .AW(AW), .WW(WW), .MKW(MKW), .J(AW - q)
			) u_digit (
				.clk(clk), .arst_n(arst_n), .en(en),
				.ctl_in(ctl_w[S]), .g_in(g_w[S]), .c_in(c_w[S]),
				.x_in(x_w[S]), .a_in(a_w[S]), .mk_in(mk_w[S]),
				.k_in(k_w[S]), .mag_in(mag_w[S]),
				.ctl_out(ctl_w[S+1]), .g_out(g_w[S+1]), .c_out(c_w[S+1]),
				.x_out(x_w[S+1]), .a_out(a_w[S+1]), .mk_out(mk_w[S+1]),
				.k_out(k_w[S+1]), .mag_out(mag_w[S+1])
			);
		end
	end

	// Round: bump the root when the residual exceeds it.
	rits_ctl_t     ctl_fin;
	logic [XW-1:0] root_fin;

	rits_final #(
		.XW(XW), .AW(AW), .WW(WW)
	) u_final (
		.clk(clk), .arst_n(arst_n), .en(en),
		.ctl_in(ctl_w[NS]), .g_in(g_w[NS]), .c_in(c_w[NS]),
		.x_in(x_w[NS]), .a_in(a_w[NS]),
		.ctl_out(ctl_fin), .root(root_fin)
	);

	// Restore the sign, then sign-extend or wrap to the output width.
	logic [XW:0]           root_signed;
	logic [OUT_WIDTH+XW:0] root_ext;

	always_comb begin
		root_signed = ctl_fin.neg ? (~{1'b0, root_fin} + 1'b1) : {1'b0, root_fin};
		root_ext    = {{OUT_WIDTH{root_signed[XW]}}, root_signed};
	end

	// Output register: hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= root_ext[OUT_WIDTH-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign product_root = result_q;

endmodule
